FILE: src/grt_pkg.sv
// ----------------------------------------------------------------------------
// grt_pkg
// Shared types and constants of the gradient ramp table.
// ----------------------------------------------------------------------------
package grt_pkg;

  localparam int MaxStopsDef = 16;
  localparam int TableMaxDef = 4096;
  localparam int QueueDepth  = 2;

  localparam int ActW   = 2;
  localparam int PosW   = 17;
  localparam int ColorW = 32;
  localparam int EntryW = 12;
  localparam int SizeW  = 13;
  localparam int StatW  = 2;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(256);

  typedef enum logic [ActW-1:0] {
    ACT_APPEND = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_NO_STOPS = 2'd1,
    ST_BEYOND   = 2'd2,
    ST_DROPPED  = 2'd3
  } status_e;

  typedef struct packed {
    action_e            act;
    logic [PosW-1:0]    pos;
    logic [ColorW-1:0]  color;
    logic [EntryW-1:0]  entry;
  } item_t;

endpackage

FILE: src/grt_front.sv
// ----------------------------------------------------------------------------
// grt_front
// Accepts requests and classifies them; unused action codes are dropped here.
// ----------------------------------------------------------------------------
module grt_front import grt_pkg::*; (
  input  logic              push,
  input  logic              q_full_i,
  input  logic [ActW-1:0]   action_i,
  input  logic [PosW-1:0]   stop_position_i,
  input  logic [ColorW-1:0] stop_color_i,
  input  logic [EntryW-1:0] entry_index_i,
  output logic              q_push_o,
  output item_t             q_item_o
);

  logic known;

  always_comb begin
    unique case (action_i)
      ACT_APPEND, ACT_CLEAR, ACT_READ: known = 1'b1;
      default:                         known = 1'b0;
    endcase
  end

  assign q_push_o       = push && !q_full_i && known;
  assign q_item_o.act   = action_e'(action_i);
  assign q_item_o.pos   = stop_position_i;
  assign q_item_o.color = stop_color_i;
  assign q_item_o.entry = entry_index_i;

endmodule

FILE: src/grt_fifo.sv
// ----------------------------------------------------------------------------
// grt_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module grt_fifo import grt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

FILE: src/grt_back.sv
// ----------------------------------------------------------------------------
// grt_back
// Executes queued requests: stores stops, scans segments and interpolates.
// ----------------------------------------------------------------------------
module grt_back import grt_pkg::*; #(
  parameter int MAX_STOPS = MaxStopsDef,
  parameter int TABLE_MAX = TableMaxDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SizeW-1:0]  table_size_i,
  input  logic              item_valid_i,
  input  item_t             item_i,
  output logic              item_pop_o,
  output logic              empty,
  input  logic              pop,
  output logic [ColorW-1:0] entry_color_o,
  output logic [StatW-1:0]  status_o
);

  localparam int IdxW = $clog2(MAX_STOPS);
  localparam int CntW = $clog2(MAX_STOPS + 1);
  localparam int DivW = SizeW + 8;
  localparam int RemW = SizeW + 1;
  localparam int CycW = $clog2(DivW);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_MUL    = 6'b000100,
    S_DIV    = 6'b001000,
    S_FIX    = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_COLOR = 2'd1,
    MODE_LERP  = 2'd2
  } mode_e;

  function automatic logic [7:0] premul_chan(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] t;
    logic [15:0] s;
    t = c * a;
    s = t + {8'd0, t[15:8]} + 16'h0080;
    return s[15:8];
  endfunction

  state_e state_q, state_d;

  logic [SizeW-1:0]  stop_idx_q [MAX_STOPS];
  logic [ColorW-1:0] stop_col_q [MAX_STOPS];
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic [IdxW-1:0]   i_q, i_d;
  logic [EntryW-1:0] entry_q, entry_d;
  logic [SizeW-1:0]  prev_idx_q, prev_idx_d;
  logic [ColorW-1:0] prev_col_q, prev_col_d;
  mode_e             mode_q, mode_d;
  logic [ColorW-1:0] from_q, from_d, to_q, to_d;
  logic [SizeW-1:0]  j_q, j_d, den_q, den_d;
  logic [RemW-1:0]   rem_q [4];
  logic [RemW-1:0]   rem_d [4];
  logic [DivW-1:0]   quo_q [4];
  logic [DivW-1:0]   quo_d [4];
  logic [3:0]        neg_q, neg_d;
  logic [CycW-1:0]   cyc_q, cyc_d;
  logic [ColorW-1:0] res_col_q, res_col_d;
  status_e           res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  logic [ColorW-1:0] out_col_q, out_col_d;
  status_e           out_st_q, out_st_d;

  // append datapath
  logic [SizeW-1:0]       size_eff;
  logic [PosW+SizeW-1:0]  idx_prod;
  logic [PosW+SizeW:0]    idx_rnd;
  logic [PosW+SizeW-16:0] idx_raw;
  logic [SizeW-1:0]       idx_new;
  logic [ColorW-1:0]      col_new;
  logic                   stop_we;

  assign size_eff = (32'(table_size_i) > TABLE_MAX) ? SizeW'(TABLE_MAX) : table_size_i;
  assign idx_prod = item_i.pos * size_eff;
  assign idx_rnd  = {1'b0, idx_prod} + (PosW+SizeW+1)'(32768);
  assign idx_raw  = idx_rnd[PosW+SizeW:16];
  assign idx_new  = (idx_raw > (PosW+SizeW-15)'(size_eff)) ? size_eff
                                                            : idx_raw[SizeW-1:0];
  assign col_new  = {item_i.color[31:24],
                     premul_chan(item_i.color[23:16], item_i.color[31:24]),
                     premul_chan(item_i.color[15:8],  item_i.color[31:24]),
                     premul_chan(item_i.color[7:0],   item_i.color[31:24])};

  // scan datapath
  logic [SizeW-1:0]  cur_idx;
  logic [ColorW-1:0] cur_col;
  logic [SizeW-1:0]  entry_x;
  logic [CntW-1:0]   last_cnt;

  assign cur_idx  = stop_idx_q[i_q];
  assign cur_col  = stop_col_q[i_q];
  assign entry_x  = SizeW'(entry_q);
  assign last_cnt = cnt_q - CntW'(1);

  logic             slot_free;
  assign slot_free = !out_valid_q || pop;

  always_comb begin
    logic [8:0]      diff;
    logic [7:0]      mag;
    logic [RemW-1:0] sh;
    logic [7:0]      fk, qk;
    logic [ColorW-1:0] lerp;
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    entry_d     = entry_q;
    prev_idx_d  = prev_idx_q;
    prev_col_d  = prev_col_q;
    mode_d      = mode_q;
    from_d      = from_q;
    to_d        = to_q;
    j_d         = j_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    cyc_d       = cyc_q;
    res_col_d   = res_col_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_col_d   = out_col_q;
    out_st_d    = out_st_q;
    item_pop_o  = 1'b0;
    stop_we     = 1'b0;
    diff        = '0;
    mag         = '0;
    sh          = '0;
    fk          = '0;
    qk          = '0;
    lerp        = '0;

    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          res_col_d  = '0;
          case (item_i.act)
            ACT_APPEND: begin
              if (cnt_q < CntW'(MAX_STOPS)) begin
                stop_we  = 1'b1;
                cnt_d    = cnt_q + CntW'(1);
                res_st_d = ST_OK;
              end else begin
                res_st_d = ST_DROPPED;
              end
              state_d = S_FINISH;
            end
            ACT_CLEAR: begin
              cnt_d = '0;
            end
            ACT_READ: begin
              entry_d = item_i.entry;
              res_st_d = ST_OK;
              if (cnt_q == '0) begin
                res_st_d = ST_NO_STOPS;
                state_d  = S_FINISH;
              end else if (SizeW'(item_i.entry) >= size_eff) begin
                res_st_d = ST_BEYOND;
                state_d  = S_FINISH;
              end else begin
                i_d     = '0;
                mode_d  = MODE_NONE;
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (i_q == '0) begin
          if (entry_x < cur_idx) begin
            mode_d = MODE_COLOR;
            from_d = cur_col;
          end
        end else if (prev_idx_q < cur_idx && entry_x >= prev_idx_q && entry_x < cur_idx) begin
          mode_d = MODE_LERP;
          from_d = prev_col_q;
          to_d   = cur_col;
          j_d    = entry_x - prev_idx_q;
          den_d  = cur_idx - prev_idx_q - SizeW'(1);
        end
        prev_idx_d = cur_idx;
        prev_col_d = cur_col;
        if (i_q == last_cnt[IdxW-1:0]) begin
          // tail wins over every segment
          if (entry_x >= cur_idx) begin
            mode_d = MODE_COLOR;
            from_d = cur_col;
          end
          if (mode_d == MODE_LERP) begin
            state_d = S_MUL;
          end else begin
            res_col_d = (mode_d == MODE_COLOR) ? from_d : '0;
            state_d   = S_FINISH;
          end
        end else begin
          i_d = i_q + IdxW'(1);
        end
      end

      S_MUL: begin
        for (int k = 0; k < 4; k++) begin
          diff     = {1'b0, to_q[8*k +: 8]} - {1'b0, from_q[8*k +: 8]};
          neg_d[k] = diff[8];
          mag      = diff[8] ? 8'(-diff) : diff[7:0];
          quo_d[k] = mag * j_q;
          rem_d[k] = '0;
        end
        cyc_d = CycW'(DivW - 1);
        if (den_q == '0) begin
          // one-entry segment takes its start colour
          res_col_d = from_q;
          state_d   = S_FINISH;
        end else begin
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        for (int k = 0; k < 4; k++) begin
          sh = {rem_q[k][RemW-2:0], quo_q[k][DivW-1]};
          if (sh >= {1'b0, den_q}) begin
            rem_d[k] = sh - {1'b0, den_q};
            quo_d[k] = {quo_q[k][DivW-2:0], 1'b1};
          end else begin
            rem_d[k] = sh;
            quo_d[k] = {quo_q[k][DivW-2:0], 1'b0};
          end
        end
        if (cyc_q == '0) begin
          state_d = S_FIX;
        end else begin
          cyc_d = cyc_q - CycW'(1);
        end
      end

      S_FIX: begin
        for (int k = 0; k < 4; k++) begin
          fk = from_q[8*k +: 8];
          qk = quo_q[k][7:0];
          // negative steps round toward minus infinity
          if (neg_q[k]) begin
            lerp[8*k +: 8] = fk - qk - {7'd0, (rem_q[k] != '0)};
          end else begin
            lerp[8*k +: 8] = fk + qk;
          end
        end
        res_col_d = lerp;
        state_d   = S_FINISH;
      end

      S_FINISH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_col_d   = {res_col_q[31:24], res_col_q[7:0], res_col_q[15:8], res_col_q[23:16]};
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    entry_q    <= entry_d;
    prev_idx_q <= prev_idx_d;
    prev_col_q <= prev_col_d;
    mode_q     <= mode_d;
    from_q     <= from_d;
    to_q       <= to_d;
    j_q        <= j_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    neg_q      <= neg_d;
    cyc_q      <= cyc_d;
    res_col_q  <= res_col_d;
    res_st_q   <= res_st_d;
    out_col_q  <= out_col_d;
    out_st_q   <= out_st_d;
    if (stop_we) begin
      stop_idx_q[cnt_q[IdxW-1:0]] <= idx_new;
      stop_col_q[cnt_q[IdxW-1:0]] <= col_new;
    end
  end

  assign empty         = !out_valid_q;
  assign entry_color_o = out_col_q;
  assign status_o      = out_st_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_STOPS))
    else $error("stop count beyond capacity");

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> den_q != '0)
    else $error("division started with zero divisor");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FINISH)
    else $error("result loaded outside finish");

endmodule

FILE: src/gradient_ramp_table.sv
// ----------------------------------------------------------------------------
// gradient_ramp_table
// Multi-stop colour gradient lookup: stores stops, answers table entries.
// ----------------------------------------------------------------------------
// Requests enter a two-deep queue and are carried out one at a time. An
// append and a refused read (no stops, index beyond size) go straight to
// the result stage, and a clear only resets the stop count and gives no
// result; otherwise a read scans the stored stops one per cycle and, inside
// a segment, runs four parallel restoring dividers, with a setup step
// before them and a rounding step after them.
// The result waits in an output register until popped while new requests
// keep queuing. Stops are kept in registers, so there is no clearing pass.
module gradient_ramp_table import grt_pkg::*; #(
  parameter int MAX_STOPS = MaxStopsDef,
  parameter int TABLE_MAX = TableMaxDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SizeW-1:0]  cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  logic [ActW-1:0]   action_i,
  input  logic [PosW-1:0]   stop_position_i,
  input  logic [ColorW-1:0] stop_color_i,
  input  logic [EntryW-1:0] entry_index_i,
  output logic              empty,
  input  logic              pop,
  output logic [ColorW-1:0] entry_color_o,
  output logic [StatW-1:0]  status_o
);

  logic [SizeW-1:0] table_size_q, table_size_d;
  logic             q_push, q_full, q_valid, q_pop;
  item_t            q_in, q_out;

  assign table_size_d = cfg_we_i ? cfg_wdata_i : table_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= SizeReset;
    end else begin
      table_size_q <= table_size_d;
    end
  end

  assign full = q_full;

  grt_front u_front (
    .push            (push),
    .q_full_i        (q_full),
    .action_i        (action_i),
    .stop_position_i (stop_position_i),
    .stop_color_i    (stop_color_i),
    .entry_index_i   (entry_index_i),
    .q_push_o        (q_push),
    .q_item_o        (q_in)
  );

  grt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_out),
    .pop_i   (q_pop)
  );

  grt_back #(
    .MAX_STOPS (MAX_STOPS),
    .TABLE_MAX (TABLE_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .table_size_i  (table_size_q),
    .item_valid_i  (q_valid),
    .item_i        (q_out),
    .item_pop_o    (q_pop),
    .empty         (empty),
    .pop           (pop),
    .entry_color_o (entry_color_o),
    .status_o      (status_o)
  );

endmodule
